/* hw/rtl/rstd_pkg.sv */
// Shared types and constants for the running standardizer.
// Used by rstd_div, rstd_mul and running_standardizer_core.
package rstd_pkg;

    localparam int QW  = 48;    // serial operand / quotient width
    localparam int DVW = 33;    // divisor and remainder width
    localparam int STW = 6;     // step counter width

    localparam logic [STW-1:0] STEPS_MEAN  = 6'd48;
    localparam logic [STW-1:0] STEPS_VAR   = 6'd46;
    localparam logic [STW-1:0] STEPS_SCALE = 6'd31;
    localparam logic [STW-1:0] STEPS_MUL   = 6'd48;

    localparam logic [30:0] MAX31   = 31'h7FFF_FFFF;
    localparam logic [31:0] OFF_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] OFF_MIN = 32'h8000_0000;

    localparam logic REG_DESIRED_MEAN = 1'b0;
    localparam logic REG_DESIRED_STD  = 1'b1;

    typedef struct packed {
        logic           start;
        logic [STW-1:0] steps;
    } div_cmd_t;

endpackage

/* hw/rtl/rstd_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on rstd_pkg.
module rstd_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  rstd_pkg::div_cmd_t       cmd,
    input  logic [rstd_pkg::DVW-1:0] rem_init,
    input  logic [rstd_pkg::QW-1:0]  dividend,
    input  logic [rstd_pkg::DVW-1:0] divisor,
    output logic [rstd_pkg::QW-1:0]  quotient,
    output logic                     done
);
    import rstd_pkg::*;

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [STW-1:0] cnt_reg, cnt_next;
    logic [DVW-1:0] rem_reg, rem_next;
    logic [DVW-1:0] dvs_reg, dvs_next;
    logic [QW-1:0]  dvd_reg, dvd_next;
    logic [QW-1:0]  quo_reg, quo_next;
    logic [DVW:0]   part;
    logic [DVW:0]   diff;
    logic           ge;

    always_comb
    begin
        part      = {rem_reg, dvd_reg[QW-1]};
        diff      = part - {1'b0, dvs_reg};
        ge        = (part >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = cmd.steps;
            rem_next  = rem_init;
            dvs_next  = divisor;
            dvd_next  = dividend;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DVW-1:0] : part[DVW-1:0];
            dvd_next = {dvd_reg[QW-2:0], 1'b0};
            quo_next = {quo_reg[QW-2:0], ge};
            cnt_next = cnt_reg - STW'(1);
            if (cnt_reg == STW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

/* hw/rtl/rstd_mul.sv */
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
// Depends on rstd_pkg.
module rstd_mul (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [rstd_pkg::QW-1:0]   a,
    input  logic [rstd_pkg::QW-1:0]   b,
    output logic [2*rstd_pkg::QW-1:0] prod,
    output logic                      done
);
    import rstd_pkg::*;

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [STW-1:0]  cnt_reg, cnt_next;
    logic [QW-1:0]   a_reg, a_next;
    logic [2*QW-1:0] acc_reg, acc_next;
    logic [QW:0]     sum;

    always_comb
    begin
        sum       = {1'b0, acc_reg[2*QW-1:QW]} + (acc_reg[0] ? {1'b0, a_reg} : '0);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = STEPS_MUL;
            a_next    = a;
            acc_next  = {{QW{1'b0}}, b};
        end
        else if (busy_reg)
        begin
            acc_next = {sum, acc_reg[QW-1:1]};
            cnt_next = cnt_reg - STW'(1);
            if (cnt_reg == STW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        acc_reg <= acc_next;
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule

/* hw/rtl/running_standardizer_core.sv */
// Running standardizer top level: Welford mean / squared-deviation update,
// serial square root, scale and offset. Depends on rstd_pkg, rstd_div, rstd_mul.
//
//   channel | signals                                   | role
//   --------+-------------------------------------------+---------------------------
//   in      | in_valid, in_ready, sample                | one sample per transfer
//   out     | out_valid, out_ready, sample_count,       | one result per sample
//           | mean_estimate, std_estimate,              |
//           | scale_factor, offset_value                |
//   cfg     | cfg_we, cfg_index, cfg_wdata              | write-only registers
//
// One sample at a time: the next input transfer waits for up to three passes
// of the 1-bit/cycle divider, two of the serial multiplier and a square root.
// Saturated variance skips a divide and the root; saturated scale skips one divide.
// Reset clears count, mean and sum; desired_mean = 0, desired_std = 1.0.
// The result sits in an output register, so a new sample is taken while it waits;
// a stalled output only holds the last step until the register frees up.
module running_standardizer_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] sample,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        sample_count,
    output logic signed [31:0] mean_estimate,
    output logic [30:0]        std_estimate,
    output logic [30:0]        scale_factor,
    output logic signed [31:0] offset_value,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_wdata
);
    import rstd_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE = 16'b0000_0000_0000_0001,
        S_DELTA = 16'b0000_0000_0000_0010,
        S_ABS  = 16'b0000_0000_0000_0100,
        S_MDIV = 16'b0000_0000_0000_1000,
        S_D2   = 16'b0000_0000_0001_0000,
        S_ABS2 = 16'b0000_0000_0010_0000,
        S_MUL1 = 16'b0000_0000_0100_0000,
        S_VCHK = 16'b0000_0000_1000_0000,
        S_VDIV = 16'b0000_0001_0000_0000,
        S_SQRT = 16'b0000_0010_0000_0000,
        S_SCHK = 16'b0000_0100_0000_0000,
        S_SDIV = 16'b0000_1000_0000_0000,
        S_DIFF = 16'b0001_0000_0000_0000,
        S_DABS = 16'b0010_0000_0000_0000,
        S_MUL2 = 16'b0100_0000_0000_0000,
        S_FIN  = 16'b1000_0000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] dmean_reg, dmean_next;
    logic [30:0] dstd_reg, dstd_next;
    logic [31:0] count_reg, count_next;
    logic [47:0] mean_reg, mean_next;
    logic [63:0] sq_reg, sq_next;
    logic        out_valid_reg, out_valid_next;

    logic [31:0] x_reg, x_next;
    logic [48:0] t_reg, t_next;
    logic [47:0] mag_reg, mag_next;
    logic        neg_reg, neg_next;
    logic [61:0] rad_reg, rad_next;
    logic [32:0] srem_reg, srem_next;
    logic [30:0] root_reg, root_next;
    logic [4:0]  step_reg, step_next;
    logic [30:0] scale_reg, scale_next;
    logic [63:0] prod_reg, prod_next;

    logic [31:0] o_count_reg, o_count_next;
    logic [31:0] o_mean_reg, o_mean_next;
    logic [30:0] o_std_reg, o_std_next;
    logic [30:0] o_scale_reg, o_scale_next;
    logic [31:0] o_off_reg, o_off_next;

    div_cmd_t      div_cmd;
    logic [DVW-1:0] div_rem;
    logic [QW-1:0]  div_dvd;
    logic [DVW-1:0] div_dvs;
    logic [QW-1:0]  div_q;
    logic           div_done;

    logic            mul_start;
    logic [QW-1:0]   mul_a;
    logic [QW-1:0]   mul_b;
    logic [2*QW-1:0] mul_p;
    logic            mul_done;

    logic [48:0] t_neg;
    logic [47:0] t_abs;
    logic [48:0] x_minus_mean;
    logic [64:0] sum65;
    logic [32:0] cnt1;
    logic [32:0] rem4;
    logic [32:0] trial;
    logic        sge;
    logic [47:0] off_sh;
    logic        off_fits;
    logic [31:0] off_sat;
    logic        out_free;

    rstd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .rem_init (div_rem),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quotient (div_q),
        .done     (div_done)
    );

    rstd_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (mul_p),
        .done  (mul_done)
    );

    assign t_neg        = -t_reg;
    assign t_abs        = t_reg[48] ? t_neg[47:0] : t_reg[47:0];
    assign x_minus_mean = {x_reg[31], x_reg, 16'b0} - {mean_reg[47], mean_reg};
    assign sum65        = {1'b0, sq_reg} + {17'b0, mul_p[95:48]};
    assign cnt1         = {1'b0, count_reg} + 33'd1;
    assign rem4         = {srem_reg[30:0], rad_reg[61:60]};
    assign trial        = {root_reg[30:0], 2'b01};
    assign sge          = (rem4 >= trial);
    assign off_sh       = prod_reg[63:16];
    assign off_fits     = (&off_sh[47:31]) | ~(|off_sh[47:31]);
    assign off_sat      = off_fits ? off_sh[31:0] : (off_sh[47] ? OFF_MIN : OFF_MAX);
    assign out_free     = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        dmean_next     = dmean_reg;
        dstd_next      = dstd_reg;
        count_next     = count_reg;
        mean_next      = mean_reg;
        sq_next        = sq_reg;
        out_valid_next = out_valid_reg;
        x_next         = x_reg;
        t_next         = t_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        rad_next       = rad_reg;
        srem_next      = srem_reg;
        root_next      = root_reg;
        step_next      = step_reg;
        scale_next     = scale_reg;
        prod_next      = prod_reg;
        o_count_next   = o_count_reg;
        o_mean_next    = o_mean_reg;
        o_std_next     = o_std_reg;
        o_scale_next   = o_scale_reg;
        o_off_next     = o_off_reg;
        div_cmd        = '0;
        div_rem        = '0;
        div_dvd        = '0;
        div_dvs        = '0;
        mul_start      = 1'b0;
        mul_a          = '0;
        mul_b          = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_DESIRED_MEAN: dmean_next = cfg_wdata;
                REG_DESIRED_STD:  dstd_next  = cfg_wdata[30:0];
                default:          dmean_next = dmean_reg;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    x_next     = sample;
                    count_next = (count_reg == '1) ? count_reg : count_reg + 32'd1;
                    state_next = S_DELTA;
                end
            end
            S_DELTA:
            begin
                t_next     = x_minus_mean;
                state_next = S_ABS;
            end
            S_ABS:
            begin
                neg_next      = t_reg[48];
                mag_next      = t_abs;
                div_cmd.start = 1'b1;
                div_cmd.steps = STEPS_MEAN;
                div_dvd       = t_abs;
                div_dvs       = {1'b0, count_reg};
                state_next    = S_MDIV;
            end
            S_MDIV:
            begin
                if (div_done)
                begin
                    // quotient truncated toward zero
                    mean_next  = neg_reg ? mean_reg - div_q : mean_reg + div_q;
                    state_next = S_D2;
                end
            end
            S_D2:
            begin
                t_next     = x_minus_mean;
                state_next = S_ABS2;
            end
            S_ABS2:
            begin
                mul_start  = 1'b1;
                mul_a      = mag_reg;
                mul_b      = t_abs;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                if (mul_done)
                begin
                    sq_next    = sum65[64] ? '1 : sum65[63:0];
                    state_next = S_VCHK;
                end
            end
            S_VCHK:
            begin
                // var >= 2^46 exactly when sum >> 46 >= count + 1
                if ({15'b0, sq_reg[63:46]} >= cnt1)
                begin
                    root_next  = MAX31;
                    state_next = S_SCHK;
                end
                else
                begin
                    div_cmd.start = 1'b1;
                    div_cmd.steps = STEPS_VAR;
                    div_rem       = {15'b0, sq_reg[63:46]};
                    div_dvd       = {sq_reg[45:0], 2'b0};
                    div_dvs       = cnt1;
                    state_next    = S_VDIV;
                end
            end
            S_VDIV:
            begin
                if (div_done)
                begin
                    rad_next   = {div_q[45:0], 16'b0};
                    srem_next  = '0;
                    root_next  = '0;
                    step_next  = 5'd31;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                rad_next  = {rad_reg[59:0], 2'b0};
                srem_next = sge ? rem4 - trial : rem4;
                root_next = {root_reg[29:0], sge};
                step_next = step_reg - 5'd1;
                if (step_reg == 5'd1)
                begin
                    state_next = S_SCHK;
                end
            end
            S_SCHK:
            begin
                // also covers desired_std of zero
                if ({15'b0, root_reg[30:15]} >= dstd_reg)
                begin
                    scale_next = MAX31;
                    state_next = S_DIFF;
                end
                else
                begin
                    div_cmd.start = 1'b1;
                    div_cmd.steps = STEPS_SCALE;
                    div_rem       = {17'b0, root_reg[30:15]};
                    div_dvd       = {root_reg[14:0], 33'b0};
                    div_dvs       = {2'b0, dstd_reg};
                    state_next    = S_SDIV;
                end
            end
            S_SDIV:
            begin
                if (div_done)
                begin
                    scale_next = div_q[30:0];
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                t_next     = {{17{mean_reg[47]}}, mean_reg[47:16]}
                           - {{17{dmean_reg[31]}}, dmean_reg};
                state_next = S_DABS;
            end
            S_DABS:
            begin
                neg_next   = t_reg[48];
                mul_start  = 1'b1;
                mul_a      = t_abs;
                mul_b      = {17'b0, scale_reg};
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                if (mul_done)
                begin
                    prod_next  = neg_reg ? -mul_p[63:0] : mul_p[63:0];
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    o_count_next   = count_reg;
                    o_mean_next    = mean_reg[47:16];
                    o_std_next     = root_reg;
                    o_scale_next   = scale_reg;
                    o_off_next     = off_sat;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dmean_reg     <= '0;
            dstd_reg      <= 31'd65536;
            count_reg     <= '0;
            mean_reg      <= '0;
            sq_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dmean_reg     <= dmean_next;
            dstd_reg      <= dstd_next;
            count_reg     <= count_next;
            mean_reg      <= mean_next;
            sq_reg        <= sq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        t_reg       <= t_next;
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        rad_reg     <= rad_next;
        srem_reg    <= srem_next;
        root_reg    <= root_next;
        step_reg    <= step_next;
        scale_reg   <= scale_next;
        prod_reg    <= prod_next;
        o_count_reg <= o_count_next;
        o_mean_reg  <= o_mean_next;
        o_std_reg   <= o_std_next;
        o_scale_reg <= o_scale_next;
        o_off_reg   <= o_off_next;
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign sample_count  = o_count_reg;
    assign mean_estimate = o_mean_reg;
    assign std_estimate  = o_std_reg;
    assign scale_factor  = o_scale_reg;
    assign offset_value  = o_off_reg;

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> count_reg != '0)
        else $error("count zero after input transfer");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_MDIV || state_reg == S_VDIV || state_reg == S_SDIV))
        else $error("divider finished outside a divide state");

    a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == S_MUL1 || state_reg == S_MUL2))
        else $error("multiplier finished outside a multiply state");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("output register loaded outside final state");

endmodule
